FILE: sv/feedback_echo_delay_defines.svh
// ----------------------------------------------------------------------------
// Feedback echo delay assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_ECHO_DELAY_DEFINES_SVH
`define FEEDBACK_ECHO_DELAY_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define FED_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a same-cycle implication.
`define FED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication.
`define FED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fed_pkg.sv
// ----------------------------------------------------------------------------
// Feedback echo delay package
// Widths, register indexes, reset values and the Q1.15 round/saturate helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fed_pkg;

  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int DLY_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;
  localparam int PROD_W    = 33;
  localparam int SUM_W     = 34;
  localparam int Q_SHIFT   = 15;
  localparam int ROUND_HALF = 16384;

  localparam int BUFFER_DEPTH_DEF = 131072;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd16384;
  localparam int                DELAY_RESET = 22050;

  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd3;

  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0]         t;
    logic signed [SUM_W-Q_SHIFT:0] sh;
    logic signed [DATA_W-1:0]      r;
    t  = {s[SUM_W-1], s} + (SUM_W+1)'(ROUND_HALF);
    sh = t[SUM_W:Q_SHIFT];
    if (sh > SAT_MAX) begin
      r = DATA_W'(SAT_MAX);
    end else if (sh < SAT_MIN) begin
      r = DATA_W'(SAT_MIN);
    end else begin
      r = sh[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fed_ram.sv
// ----------------------------------------------------------------------------
// Echo memory
// Simple dual-port RAM, one write and one registered read port, read-old.
// ----------------------------------------------------------------------------
`default_nettype none

module fed_ram #(
  parameter int DEPTH  = fed_pkg::BUFFER_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = fed_pkg::DATA_W
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/fed_dly_red.sv
// ----------------------------------------------------------------------------
// Delay reduction unit
// Reduce a written delay modulo the buffer depth by reciprocal multiplication,
// quotient, remainder and final correction, each in its own registered step.
// ----------------------------------------------------------------------------
`default_nettype none

module fed_dly_red #(
  parameter int BUFFER_DEPTH = fed_pkg::BUFFER_DEPTH_DEF,
  parameter int PTR_W        = $clog2(BUFFER_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [fed_pkg::DLY_W-1:0] value_i,
  output logic                      busy_o,
  output logic [PTR_W-1:0]          delay_o
);

  import fed_pkg::*;

  localparam int CW      = ((DLY_W > PTR_W) ? DLY_W : PTR_W) + 1;
  localparam int MUL_W   = 2 * DLY_W;
  localparam int RST_MOD = DELAY_RESET % BUFFER_DEPTH;

  localparam logic [DLY_W-1:0] RECIP     = DLY_W'((longint'(1) << DLY_W) / BUFFER_DEPTH);
  localparam logic [CW-1:0]    DEPTH_EXT = CW'(BUFFER_DEPTH);

  logic [DLY_W-1:0] val_q, val_d;
  logic [DLY_W-1:0] quo_q, quo_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [2:0]       stage_q, stage_d;
  logic [MUL_W-1:0] prod;
  logic [CW-1:0]    back;

  // Quotient estimate is exact or one low; one compare and subtract fixes it
  always_comb begin
    prod    = MUL_W'(val_q) * MUL_W'(RECIP);
    back    = CW'(quo_q) * DEPTH_EXT;
    val_d   = val_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    stage_d = {stage_q[1:0], 1'b0};
    if (stage_q[0]) begin
      quo_d = prod[MUL_W-1:DLY_W];
    end
    if (stage_q[1]) begin
      rem_d = CW'(val_q) - back;
    end
    if (stage_q[2] && (rem_q >= DEPTH_EXT)) begin
      rem_d = rem_q - DEPTH_EXT;
    end
    if (load_i) begin
      val_d   = value_i;
      stage_d = 3'b001;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= '0;
      quo_q   <= '0;
      rem_q   <= CW'(RST_MOD);
      stage_q <= '0;
    end else begin
      val_q   <= val_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      stage_q <= stage_d;
    end
  end

  assign busy_o  = |stage_q;
  assign delay_o = PTR_W'(rem_q);

endmodule

`default_nettype wire

FILE: sv/feedback_echo_delay.sv
// ----------------------------------------------------------------------------
// Feedback echo delay
// Mono feedback echo over a circular delay memory, Q1.15 samples and gains.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on s_axis_* and mixed samples leave on m_axis_*, one result
//   per input transfer, in order. The config port writes dry, wet, feedback
//   gain and delay; write only while no sample is in flight.
//   Pipeline: an accepted sample passes stage 1, stage 2 and the output
//   register in turn.
//   Throughput: one sample per cycle, set by the single read-modify-write of
//   the echo RAM per sample, while no stall, delay reduction or read hazard
//   holds s_axis_tready low. With a delay that reduces to one sample, the
//   read waits until the previous sample's write value can be forwarded.
//   A delay write is reduced modulo the depth in the reduction unit;
//   s_axis_tready stays low meanwhile.
//   Reset: registers take their defaults and the memory reads as zero until
//   each entry is first written; no clearing pass, input is ready at once.
//   Stall: with m_axis_tready low the output register holds, the pipeline
//   fills up behind it and s_axis_tready drops when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "feedback_echo_delay_defines.svh"

module feedback_echo_delay #(
  parameter int BUFFER_DEPTH = fed_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fed_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fed_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fed_pkg::DATA_W-1:0]    s_axis_tdata,  // [15:0] in_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fed_pkg::DATA_W-1:0]    m_axis_tdata   // [15:0] out_sample
);

  import fed_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_FWD
  } src_e;

  logic [GAIN_W-1:0] dry_q, wet_q, fb_q;
  logic              dly_busy;
  logic [PTR_W-1:0]  dly;

  logic [PTR_W-1:0] wp_q;
  logic             wrapped_q;
  logic [PTR_W:0]   diff;
  logic [PTR_W-1:0] rp;
  logic             accept;
  logic             hazard1, hazard2;

  logic                     s1_valid_q;
  logic signed [DATA_W-1:0] s1_x_q;
  logic [PTR_W-1:0]         s1_wp_q, s1_rp_q;
  src_e                     s1_src_q;
  logic [DATA_W-1:0]        fwd_q;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] delayed;

  logic signed [GAIN_W:0]   dry_s, wet_s, fb_s;
  logic signed [PROD_W-1:0] p_dry, p_wet, p_fb;

  logic                     s2_valid_q;
  logic [PTR_W-1:0]         s2_wp_q;
  logic signed [DATA_W-1:0] s2_x_q;
  logic signed [PROD_W-1:0] s2_dry_q, s2_wet_q, s2_fb_q;
  logic signed [SUM_W-1:0]  mix_sum, fb_sum;
  logic signed [DATA_W-1:0] out_val, stored_val;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;

  logic s2_adv, s2_free, s1_adv, s1_free;

  fed_dly_red #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .PTR_W       (PTR_W)
  ) u_dly_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cfg_we_i && (cfg_idx_i == REG_DELAY)),
    .value_i(cfg_wdata_i[DLY_W-1:0]),
    .busy_o (dly_busy),
    .delay_o(dly)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q <= GAIN_RESET;
      wet_q <= GAIN_RESET;
      fb_q  <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DRY_GAIN: dry_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_WET_GAIN: wet_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_FB_GAIN:  fb_q  <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read address and hazard detection
  always_comb begin
    diff = {1'b0, wp_q} - {1'b0, dly};
    if (diff[PTR_W]) begin
      rp = PTR_W'(diff + (PTR_W+1)'(BUFFER_DEPTH));
    end else begin
      rp = diff[PTR_W-1:0];
    end
  end

  assign s2_adv  = s2_valid_q && (!out_valid_q || m_axis_tready);
  assign s2_free = !s2_valid_q || s2_adv;
  assign s1_adv  = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s1_adv;

  assign hazard1 = s1_valid_q && (rp == s1_wp_q);
  assign hazard2 = s2_valid_q && (rp == s2_wp_q);

  assign s_axis_tready = s1_free && !dly_busy && !hazard1 && !(hazard2 && !s2_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  fed_ram #(
    .DEPTH (BUFFER_DEPTH),
    .ADDR_W(PTR_W),
    .DATA_W(DATA_W)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (s2_adv),
    .wr_addr_i(s2_wp_q),
    .wr_data_i(stored_val),
    .rd_en_i  (accept),
    .rd_addr_i(rp),
    .rd_data_o(rd_data)
  );

  // Stage 1: select delayed sample, multiply
  always_comb begin
    case (s1_src_q)
      SRC_MEM: delayed = rd_data;
      SRC_FWD: delayed = fwd_q;
      default: delayed = '0;
    endcase
  end

  assign dry_s = {1'b0, dry_q};
  assign wet_s = {1'b0, wet_q};
  assign fb_s  = {1'b0, fb_q};
  assign p_dry = dry_s * s1_x_q;
  assign p_wet = wet_s * delayed;
  assign p_fb  = fb_s * delayed;

  // Stage 2: sum, round, saturate
  assign mix_sum    = SUM_W'(s2_dry_q) + SUM_W'(s2_wet_q);
  assign fb_sum     = (SUM_W'(s2_x_q) <<< Q_SHIFT) + SUM_W'(s2_fb_q);
  assign out_val    = round_sat(mix_sum);
  assign stored_val = round_sat(fb_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_src_q    <= SRC_ZERO;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
        if (wp_q == PTR_LAST) begin
          wrapped_q <= 1'b1;
        end
        s1_valid_q <= 1'b1;
        if (hazard2) begin
          s1_src_q <= SRC_FWD;
        end else if (wrapped_q || (rp < wp_q)) begin
          s1_src_q <= SRC_MEM;
        end else begin
          s1_src_q <= SRC_ZERO;
        end
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q  <= s_axis_tdata;
      s1_wp_q <= wp_q;
      s1_rp_q <= rp;
      if (hazard2) begin
        fwd_q <= stored_val;
      end
    end
    if (s1_adv) begin
      s2_wp_q  <= s1_wp_q;
      s2_x_q   <= s1_x_q;
      s2_dry_q <= p_dry;
      s2_wet_q <= p_wet;
      s2_fb_q  <= p_fb;
    end
    if (s2_adv) begin
      out_data_q <= out_val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `FED_ASSERT_IMP(a_no_stale_read, s1_valid_q && s2_valid_q && (s1_src_q == SRC_MEM), s1_rp_q != s2_wp_q, "memory read overlaps pending write")
  `FED_ASSERT_IMP(a_fwd_has_writer, accept && hazard2, s2_adv, "forward source not written this cycle")
  `FED_ASSERT_NXT(a_accept_fills_s1, accept, s1_valid_q && (s1_wp_q == $past(wp_q)), "transfer lost in stage 1")
  `FED_ASSERT(a_delay_in_range, dly_busy || ({1'b0, dly} < (PTR_W+1)'(BUFFER_DEPTH)), "delay not reduced")

endmodule

`default_nettype wire
